>>> rtl/ps2mct_pkg.sv
package ps2mct_pkg;

    // field widths
    localparam int DATA_W  = 8;
    localparam int CFG_W   = 13;
    localparam int OUT_W   = 12;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // register map, indexed by paddr[2]
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // header bits
    localparam int HDR_VALID_BIT = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam int HDR_XOVF_BIT  = 6;
    localparam int HDR_YOVF_BIT  = 7;

    // overflow adjustments and clamp margins
    localparam logic [9:0] X_OVF_ADJ = 10'd510;
    localparam logic [9:0] Y_OVF_ADJ = 10'd255;
    localparam logic [4:0] X_MARGIN  = 5'd8;
    localparam logic [4:0] Y_MARGIN  = 5'd16;

    // packet queue
    localparam int PKT_Q_DEPTH = 2;
    localparam int PKT_Q_PTR_W = 1;
    localparam int PKT_Q_CNT_W = 2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XBYTE  = 2'd1,
        PH_YBYTE  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] header;
        logic [DATA_W-1:0] x_byte;
        logic [DATA_W-1:0] y_byte;
    } pkt_t;

    typedef struct packed {
        logic [CFG_W-1:0] screen_width;
        logic [CFG_W-1:0] screen_height;
    } screen_cfg_t;

endpackage

>>> rtl/ps2mct_front.sv
module ps2mct_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ps2mct_pkg::DATA_W-1:0] s_data_byte,
    output logic                        pkt_valid,
    output ps2mct_pkg::pkt_t            pkt,
    input  logic                        pkt_ready
);

    ps2mct_pkg::phase_t phase_reg, phase_next;
    logic [ps2mct_pkg::DATA_W-1:0] header_reg, header_next;
    logic [ps2mct_pkg::DATA_W-1:0] x_byte_reg, x_byte_next;
    logic accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ps2mct_pkg::PH_HEADER;
        end else begin
            phase_reg <= phase_next;
        end
        header_reg <= header_next;
        x_byte_reg <= x_byte_next;
    end

    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        x_byte_next = x_byte_reg;
        s_ready     = 1'b1;
        pkt_valid   = 1'b0;
        pkt.header  = header_reg;
        pkt.x_byte  = x_byte_reg;
        pkt.y_byte  = s_data_byte;
        case (phase_reg)
            ps2mct_pkg::PH_XBYTE: begin
                if (accept) begin
                    x_byte_next = s_data_byte;
                    phase_next  = ps2mct_pkg::PH_YBYTE;
                end
            end
            ps2mct_pkg::PH_YBYTE: begin
                // last byte goes straight into the queue
                s_ready   = pkt_ready;
                pkt_valid = s_valid;
                if (accept) begin
                    phase_next = ps2mct_pkg::PH_HEADER;
                end
            end
            default: begin
                // wait for a byte with the always-one header bit set
                if (accept && s_data_byte[ps2mct_pkg::HDR_VALID_BIT]) begin
                    header_next = s_data_byte;
                    phase_next  = ps2mct_pkg::PH_XBYTE;
                end else if (accept) begin
                    phase_next = ps2mct_pkg::PH_HEADER;
                end
            end
        endcase
    end

endmodule

>>> rtl/ps2mct_queue.sv
module ps2mct_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  ps2mct_pkg::pkt_t push_pkt,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ps2mct_pkg::pkt_t pop_pkt
);

    ps2mct_pkg::pkt_t entry_reg [ps2mct_pkg::PKT_Q_DEPTH];
    logic [ps2mct_pkg::PKT_Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ps2mct_pkg::PKT_Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ps2mct_pkg::PKT_Q_CNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign push_ready = (count_reg != ps2mct_pkg::PKT_Q_CNT_W'(ps2mct_pkg::PKT_Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_pkt    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

>>> rtl/ps2mct_back.sv
module ps2mct_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ps2mct_pkg::screen_cfg_t      cfg,
    input  logic                         pkt_valid,
    output logic                         pkt_ready,
    input  ps2mct_pkg::pkt_t             pkt,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ps2mct_pkg::OUT_W-1:0] m_cursor_x,
    output logic [ps2mct_pkg::OUT_W-1:0] m_cursor_y
);

    localparam int BASE_W = (COORD_BITS > ps2mct_pkg::CFG_W) ? COORD_BITS : ps2mct_pkg::CFG_W;
    localparam int SW     = BASE_W + 2;
    localparam logic signed [SW-1:0] COORD_MAX_S = SW'((64'd1 << COORD_BITS) - 64'd1);

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic signed [SW-1:0]           v,
        input logic [ps2mct_pkg::CFG_W-1:0]   size,
        input logic [4:0]                     margin
    );
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] res;
        hi = $signed({{(SW-ps2mct_pkg::CFG_W){1'b0}}, size})
           - $signed({{(SW-5){1'b0}}, margin});
        if (hi < 0) hi = '0;
        if (hi > COORD_MAX_S) hi = COORD_MAX_S;
        res = v;
        if (res < 0) res = '0;
        if (res > hi) res = hi;
        return res[COORD_BITS-1:0];
    endfunction

    // 9-bit delta with header sign, then overflow step in the sign direction
    function automatic logic signed [SW-1:0] axis_delta(
        input logic       sign,
        input logic       ovf,
        input logic [7:0] mag,
        input logic [9:0] adj
    );
        logic signed [SW-1:0] d;
        logic signed [SW-1:0] a;
        d = SW'($signed({sign, mag}));
        a = $signed({{(SW-10){1'b0}}, adj});
        if (ovf && sign) begin
            d = d - a;
        end else if (ovf) begin
            d = d + a;
        end
        return d;
    endfunction

    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic                  m_valid_reg, m_valid_next;
    logic [ps2mct_pkg::OUT_W-1:0] cursor_x_reg, cursor_x_next;
    logic [ps2mct_pkg::OUT_W-1:0] cursor_y_reg, cursor_y_next;
    logic signed [SW-1:0] dx, dy, sum_x, sum_y;
    logic [ps2mct_pkg::OUT_W+COORD_BITS-1:0] ext_x, ext_y;
    logic take;

    assign pkt_ready = !m_valid_reg || m_ready;
    assign take      = pkt_valid && pkt_ready;

    always_comb begin
        dx = axis_delta(pkt.header[ps2mct_pkg::HDR_XSIGN_BIT],
                        pkt.header[ps2mct_pkg::HDR_XOVF_BIT], pkt.x_byte, ps2mct_pkg::X_OVF_ADJ);
        dy = axis_delta(pkt.header[ps2mct_pkg::HDR_YSIGN_BIT],
                        pkt.header[ps2mct_pkg::HDR_YOVF_BIT], pkt.y_byte, ps2mct_pkg::Y_OVF_ADJ);
        sum_x = $signed({{(SW-COORD_BITS){1'b0}}, pos_x_reg}) + dx;
        // screen y grows downward
        sum_y = $signed({{(SW-COORD_BITS){1'b0}}, pos_y_reg}) - dy;
        pos_x_next = take ? clamp_axis(sum_x, cfg.screen_width, ps2mct_pkg::X_MARGIN)
                          : pos_x_reg;
        pos_y_next = take ? clamp_axis(sum_y, cfg.screen_height, ps2mct_pkg::Y_MARGIN)
                          : pos_y_reg;
        ext_x = {{ps2mct_pkg::OUT_W{1'b0}}, pos_x_next};
        ext_y = {{ps2mct_pkg::OUT_W{1'b0}}, pos_y_next};
        cursor_x_next = take ? ext_x[ps2mct_pkg::OUT_W-1:0] : cursor_x_reg;
        cursor_y_next = take ? ext_y[ps2mct_pkg::OUT_W-1:0] : cursor_y_reg;
        m_valid_next  = take || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            m_valid_reg <= m_valid_next;
        end
        cursor_x_reg <= cursor_x_next;
        cursor_y_reg <= cursor_y_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_cursor_x = cursor_x_reg;
    assign m_cursor_y = cursor_y_reg;

endmodule

>>> rtl/ps2_mouse_packet_cursor_tracker.sv
// a completed packet is registered in the packet queue, then the cursor result in the m_valid output register
// throughput: one byte beat per cycle while the packet queue has room; one cursor beat per completed packet
// the 2-entry packet queue lets byte framing run while the cursor output is stalled
// reset (aresetn low, synchronous): framing back to header search, cursor to 0,0,
// screen size to 640 x 480, no result pending
module ps2_mouse_packet_cursor_tracker #(
    parameter int COORD_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // byte input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ps2mct_pkg::DATA_W-1:0]     s_data_byte,
    // cursor result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ps2mct_pkg::OUT_W-1:0]      m_cursor_x,
    output logic [ps2mct_pkg::OUT_W-1:0]      m_cursor_y,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ps2mct_pkg::APB_AW-1:0]     paddr,
    input  logic [ps2mct_pkg::APB_DW-1:0]     pwdata,
    output logic [ps2mct_pkg::APB_DW-1:0]     prdata,
    output logic                              pready
);

    // screen size registers, written in the access phase
    logic [ps2mct_pkg::CFG_W-1:0] screen_width_reg, screen_width_next;
    logic [ps2mct_pkg::CFG_W-1:0] screen_height_reg, screen_height_next;
    logic                         reg_wr;
    ps2mct_pkg::screen_cfg_t      cfg;

    // front -> queue -> back
    logic             fq_valid, fq_ready;
    ps2mct_pkg::pkt_t fq_pkt;
    logic             qb_valid, qb_ready;
    ps2mct_pkg::pkt_t qb_pkt;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_comb begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        if (reg_wr) begin
            case (paddr[2])
                ps2mct_pkg::REG_SCREEN_WIDTH:  screen_width_next  = pwdata[ps2mct_pkg::CFG_W-1:0];
                ps2mct_pkg::REG_SCREEN_HEIGHT: screen_height_next = pwdata[ps2mct_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= ps2mct_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= ps2mct_pkg::SCREEN_HEIGHT_RST;
        end else begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
        end
    end

    // read mux, zero-extended to the bus
    always_comb begin
        case (paddr[2])
            ps2mct_pkg::REG_SCREEN_WIDTH:
                prdata = ps2mct_pkg::APB_DW'(screen_width_reg);
            ps2mct_pkg::REG_SCREEN_HEIGHT:
                prdata = ps2mct_pkg::APB_DW'(screen_height_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.screen_width  = screen_width_reg;
    assign cfg.screen_height = screen_height_reg;

    // framing: header search, then x byte, then y byte completes a packet
    ps2mct_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .pkt_valid   (fq_valid),
        .pkt         (fq_pkt),
        .pkt_ready   (fq_ready)
    );

    // completed packets wait here while the cursor output is stalled
    ps2mct_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_pkt   (fq_pkt),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_pkt    (qb_pkt)
    );

    // delta decode, position add and clamp, registered result
    ps2mct_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .pkt_valid  (qb_valid),
        .pkt_ready  (qb_ready),
        .pkt        (qb_pkt),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cursor_x (m_cursor_x),
        .m_cursor_y (m_cursor_y)
    );

endmodule

>>> rtl/ps2mct_checker.sv
module ps2mct_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ps2mct_pkg::OUT_W-1:0]  m_cursor_x,
    input logic [ps2mct_pkg::OUT_W-1:0]  m_cursor_y,
    input logic                          pready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_x) && $stable(m_cursor_y))
        else $error("result beat changed while stalled");

    // with nothing pending at the output, the queue cannot be full
    a_in_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a new result follows a closing byte beat, through the packet queue and the output register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a byte beat two cycles before");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("register port wait state");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_cursor_x (m_cursor_x),
    .m_cursor_y (m_cursor_y),
    .pready     (pready)
);

>>> dv/ps2_cursor_checker.sv
`timescale 1ns / 1ps

module ps2_cursor_checker #(
    parameter int COORD_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [ps2mct_pkg::DATA_W-1:0]     s_data_byte,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [ps2mct_pkg::OUT_W-1:0]      m_cursor_x,
    input  logic [ps2mct_pkg::OUT_W-1:0]      m_cursor_y,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [ps2mct_pkg::APB_AW-1:0]     paddr,
    input  logic [ps2mct_pkg::APB_DW-1:0]     pwdata,
    output int unsigned                       mismatch_count,
    output int unsigned                       cursor_backlog
);

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    typedef struct {
        logic [ps2mct_pkg::OUT_W-1:0] x;
        logic [ps2mct_pkg::OUT_W-1:0] y;
    } cursor_t;

    ps2mct_pkg::phase_t            framing;
    logic [ps2mct_pkg::DATA_W-1:0] held_header;
    logic [ps2mct_pkg::DATA_W-1:0] held_x_byte;
    int                            pos_x;
    int                            pos_y;
    logic [ps2mct_pkg::CFG_W-1:0]  width_reg;
    logic [ps2mct_pkg::CFG_W-1:0]  height_reg;
    cursor_t                       cursors_due[$];

    // 9-bit signed movement, overflow pushes further along the sign
    function automatic int axis_delta(logic [ps2mct_pkg::DATA_W-1:0] mag, logic neg, logic ovf,
                                      int adj);
        int d;
        d = int'(mag);
        if (neg) begin
            d = d - 256;
            if (ovf) d = d - adj;
        end else if (ovf) begin
            d = d + adj;
        end
        return d;
    endfunction

    function automatic int clamp_to_screen(int v, logic [ps2mct_pkg::CFG_W-1:0] size, int margin);
        int hi;
        hi = int'(size) - margin;
        if (hi < 0) hi = 0;
        if (hi > COORD_MAX) hi = COORD_MAX;
        if (v < 0) v = 0;
        if (v > hi) v = hi;
        return v;
    endfunction

    always @(posedge aclk) begin : track
        cursor_t want;
        cursor_t made;
        int      dx;
        int      dy;
        if (!aresetn) begin
            framing        = ps2mct_pkg::PH_HEADER;
            held_header    = '0;
            held_x_byte    = '0;
            pos_x          = 0;
            pos_y          = 0;
            width_reg      = ps2mct_pkg::SCREEN_WIDTH_RST;
            height_reg     = ps2mct_pkg::SCREEN_HEIGHT_RST;
            cursors_due.delete();
            cursor_backlog = 0;
            mismatch_count = 0;
        end else begin
            // compare before predicting, a result never shares an edge with its byte
            if (m_valid && m_ready) begin
                if (cursors_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("[%0t] cursor beat with nothing expected: x %0d y %0d",
                                 $time, m_cursor_x, m_cursor_y);
                    mismatch_count++;
                end else begin
                    want = cursors_due.pop_front();
                    if (m_cursor_x !== want.x || m_cursor_y !== want.y) begin
                        if (mismatch_count < 10)
                            $display("[%0t] cursor beat wrong: x exp %0d got %0d, y exp %0d got %0d",
                                     $time, want.x, m_cursor_x, want.y, m_cursor_y);
                        mismatch_count++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                case (framing)
                    ps2mct_pkg::PH_XBYTE: begin
                        held_x_byte = s_data_byte;
                        framing     = ps2mct_pkg::PH_YBYTE;
                    end
                    ps2mct_pkg::PH_YBYTE: begin
                        framing = ps2mct_pkg::PH_HEADER;
                        dx = axis_delta(held_x_byte, held_header[ps2mct_pkg::HDR_XSIGN_BIT],
                                        held_header[ps2mct_pkg::HDR_XOVF_BIT],
                                        int'(ps2mct_pkg::X_OVF_ADJ));
                        dy = axis_delta(s_data_byte, held_header[ps2mct_pkg::HDR_YSIGN_BIT],
                                        held_header[ps2mct_pkg::HDR_YOVF_BIT],
                                        int'(ps2mct_pkg::Y_OVF_ADJ));
                        pos_x = clamp_to_screen(pos_x + dx, width_reg,
                                                int'(ps2mct_pkg::X_MARGIN));
                        // screen y grows downward
                        pos_y = clamp_to_screen(pos_y - dy, height_reg,
                                                int'(ps2mct_pkg::Y_MARGIN));
                        made.x = pos_x[ps2mct_pkg::OUT_W-1:0];
                        made.y = pos_y[ps2mct_pkg::OUT_W-1:0];
                        cursors_due.push_back(made);
                    end
                    default: begin
                        if (s_data_byte[ps2mct_pkg::HDR_VALID_BIT]) begin
                            held_header = s_data_byte;
                            framing     = ps2mct_pkg::PH_XBYTE;
                        end else begin
                            framing = ps2mct_pkg::PH_HEADER;
                        end
                    end
                endcase
            end

            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == ps2mct_pkg::REG_SCREEN_WIDTH)
                    width_reg = pwdata[ps2mct_pkg::CFG_W-1:0];
                else
                    height_reg = pwdata[ps2mct_pkg::CFG_W-1:0];
            end

            cursor_backlog = cursors_due.size();
        end
    end

endmodule

>>> dv/tb_ps2_mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor_tracker;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    // leave room for a byte still in flight through the block
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 220;
    localparam int NUM_PHASES    = 8;
    // allow several times the slowest legal run
    localparam int TIMEOUT_NS    = 5_000_000;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic [ps2mct_pkg::DATA_W-1:0]    s_data_byte;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [ps2mct_pkg::OUT_W-1:0]     m_cursor_x;
    logic [ps2mct_pkg::OUT_W-1:0]     m_cursor_y;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [ps2mct_pkg::APB_AW-1:0]    paddr;
    logic [ps2mct_pkg::APB_DW-1:0]    pwdata;
    logic [ps2mct_pkg::APB_DW-1:0]    prdata;
    logic                             pready;

    int unsigned mismatch_count;
    int unsigned cursor_backlog;

    // sender burst shaping and receiver stall pattern, retuned per phase
    int burst_left = 0;
    int gap_max    = 0;
    int ready_pct  = 100;
    int ready_hold = 0;

    // screen sizes per random phase: reset size, the lower rails, below the margins,
    // 4096, full 13-bit, a size whose limit is the range top, then a random size
    int unsigned width_plan  [NUM_PHASES] = '{640, 8, 0, 7, 4096, 8191, 4103, 0};
    int unsigned height_plan [NUM_PHASES] = '{480, 16, 0, 15, 4096, 8191, 4111, 0};

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    ps2_mouse_packet_cursor_tracker i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cursor_x  (m_cursor_x),
        .m_cursor_y  (m_cursor_y),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ps2_cursor_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_x     (m_cursor_x),
        .m_cursor_y     (m_cursor_y),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .cursor_backlog (cursor_backlog)
    );

    // receiver: ready held high or low for short random runs, the duty set by ready_pct
    always @(negedge aclk) begin
        if (ready_hold == 0) begin
            m_ready    = ($urandom_range(0, 99) < ready_pct);
            ready_hold = $urandom_range(1, 6);
        end else begin
            ready_hold--;
        end
    end

    // one byte beat; called at a falling edge, returns at a falling edge.
    // valid stays high across back-to-back beats and only drops for a gap
    task automatic push_byte(input logic [ps2mct_pkg::DATA_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid     = 1'b1;
        s_data_byte = b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
    endtask

    // setup cycle then access cycle; upper bus bits carry junk the register drops
    task automatic apb_write(input logic sel, input logic [ps2mct_pkg::CFG_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = $urandom;
        pwdata[ps2mct_pkg::CFG_W-1:0] = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // all cursor beats back, plus room for a trailing byte with no result
    task automatic drain_cursor_beats();
        s_valid = 1'b0;
        while (cursor_backlog != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin : stimulus
        logic [ps2mct_pkg::DATA_W-1:0] hdr;
        logic [1:0]                    drift;
        int                            items;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // directed bytes at the reset screen size of 640 x 480
        gap_max   = 2;
        ready_pct = 70;
        push_byte(8'h00);                                   // no header bit, dropped
        push_byte(8'hF7);                                   // every bit but the header bit
        push_byte(8'h08); push_byte(8'hFF); push_byte(8'h00);   // largest plain move right
        push_byte(8'h38); push_byte(8'h00); push_byte(8'h00);   // negative zero is -256, x hits 0
        push_byte(8'hC8); push_byte(8'hFF); push_byte(8'hFF);   // both overflows up, x rail
        push_byte(8'hF8); push_byte(8'h01); push_byte(8'h01);   // both overflows down, y rail
        push_byte(8'hFF); push_byte(8'h80); push_byte(8'h7F);   // button bits set as well
        push_byte(8'h0F); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'h48); push_byte(8'h00);                 // x overflow alone, packet left open
        drain_cursor_beats();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                width_plan[p]  = $urandom_range(8, 4096);
                height_plan[p] = $urandom_range(16, 4096);
            end
            apb_write(ps2mct_pkg::REG_SCREEN_WIDTH, width_plan[p][ps2mct_pkg::CFG_W-1:0]);
            apb_write(ps2mct_pkg::REG_SCREEN_HEIGHT, height_plan[p][ps2mct_pkg::CFG_W-1:0]);

            // idle styles rotate through three pairings of sender gaps and receiver stalls
            case (p % 3)
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 10;
            endcase
            case ((p + 1) % 3)
                0: ready_pct = 100;
                1: ready_pct = 55;
                default: ready_pct = 20;
            endcase

            items = 0;
            drift = 2'($urandom);
            while (items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 2) begin
                    // noise, may drop, start a packet or break one open
                    push_byte(ps2mct_pkg::DATA_W'($urandom_range(0, 255)));
                    items += 1;
                end else begin
                    if ($urandom_range(0, 15) == 0) drift = 2'($urandom);
                    hdr = ps2mct_pkg::DATA_W'($urandom_range(0, 255));
                    hdr[ps2mct_pkg::HDR_VALID_BIT] = 1'b1;
                    // half the packets push hard one way so the cursor rides the rails
                    if ($urandom_range(0, 1)) begin
                        hdr[ps2mct_pkg::HDR_XSIGN_BIT] = drift[0];
                        hdr[ps2mct_pkg::HDR_YSIGN_BIT] = drift[1];
                        hdr[ps2mct_pkg::HDR_XOVF_BIT]  = 1'b1;
                        hdr[ps2mct_pkg::HDR_YOVF_BIT]  = 1'b1;
                    end
                    push_byte(hdr);
                    push_byte(ps2mct_pkg::DATA_W'($urandom_range(0, 255)));
                    push_byte(ps2mct_pkg::DATA_W'($urandom_range(0, 255)));
                    items += 3;
                end
            end
            drain_cursor_beats();
        end

        if (mismatch_count == 0 && cursor_backlog == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/ps2mct_pkg.sv
rtl/ps2mct_front.sv
rtl/ps2mct_queue.sv
rtl/ps2mct_back.sv
rtl/ps2_mouse_packet_cursor_tracker.sv
rtl/ps2mct_checker.sv
dv/ps2_cursor_checker.sv
dv/tb_ps2_mouse_packet_cursor_tracker.sv
